FILE: src/assert_macros.svh
// Assertion macros shared by the point projection RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define PPTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define PPTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pptp_pkg.sv
// Shared types, slot map, constants and helpers for point projection.
// No dependencies.
package pptp_pkg;

  localparam int DEF_SCREEN_WIDTH  = 1024;
  localparam int DEF_SCREEN_HEIGHT = 768;

  localparam int NSLOT = 32;
  localparam int QBITS = 41;  // quotient bits, magnitude saturates at 2^40

  typedef logic signed [31:0] word_t;
  typedef logic [NSLOT-1:0][31:0] coef_t;

  typedef enum logic [0:0] {
    REG_PERSP = 1'b0,
    REG_DCLIP = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    KIND_LOAD  = 1'b0,
    KIND_POINT = 1'b1
  } kind_e;

  localparam int SLOT_M00   = 0;
  localparam int SLOT_M30   = 9;
  localparam int SLOT_PCX   = 12;
  localparam int SLOT_PCY   = 13;
  localparam int SLOT_PCZ   = 14;
  localparam int SLOT_WXL   = 15;
  localparam int SLOT_WXH   = 16;
  localparam int SLOT_WYL   = 17;
  localparam int SLOT_WYH   = 18;
  localparam int SLOT_WSX   = 19;
  localparam int SLOT_WSY   = 20;
  localparam int SLOT_VXL   = 21;
  localparam int SLOT_VYL   = 22;
  localparam int SLOT_FRONT = 23;
  localparam int SLOT_BACK  = 24;

  // Side data carried alongside the divider
  typedef struct packed {
    logic [7:0]         color;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               negx;
    logic               negy;
    logic               dzero;
  } side_t;

  function automatic word_t sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return word_t'(v[31:0]);
  endfunction

  // One restoring division step: {quotient bit, next remainder}
  function automatic logic [33:0] div_step(input logic [32:0] r, input logic b,
                                           input logic [32:0] ad);
    logic [33:0] t;
    logic        ge;
    t  = {r, b};
    ge = (t >= {1'b0, ad});
    return {ge, ge ? 33'(t - {1'b0, ad}) : t[32:0]};
  endfunction

endpackage

FILE: src/pptp_view.sv
// View transform, depth clip and perspective numerator setup (four stages).
// Depends on pptp_pkg.
module pptp_view (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  pptp_pkg::word_t     px_i,
  input  pptp_pkg::word_t     py_i,
  input  pptp_pkg::word_t     pz_i,
  input  logic [7:0]          color_i,
  input  logic                dclip_i,
  input  pptp_pkg::coef_t     coef_i,
  output logic                vld_o,
  output logic [63:0]         magx_o,
  output logic [63:0]         magy_o,
  output logic [32:0]         ad_o,
  output pptp_pkg::side_t     side_o,
  output logic                busy_o
);
  import pptp_pkg::*;

  word_t pt [3];
  assign pt[0] = px_i;
  assign pt[1] = py_i;
  assign pt[2] = pz_i;

  // Stage 1: nine products
  logic              v1_q;
  logic signed [63:0] prod_q [9];
  logic [7:0]        col1_q;

  for (genvar i = 0; i < 9; i++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en_i) prod_q[i] <= pt[i/3] * word_t'(coef_i[SLOT_M00 + i]);
    end
  end

  // Stage 2: floored sums, saturated
  logic  v2_q;
  word_t c_q [3];
  logic [7:0] col2_q;

  for (genvar c = 0; c < 3; c++) begin : g_sum
    logic signed [49:0] s;
    assign s = 50'(prod_q[c] >>> 16) + 50'(prod_q[3+c] >>> 16) + 50'(prod_q[6+c] >>> 16)
             + 50'(word_t'(coef_i[SLOT_M30 + c]));
    always_ff @(posedge clk_i) begin
      if (en_i) c_q[c] <= sat32(s);
    end
  end

  // Stage 3: depth clip, perspective products
  word_t pcx, pcy, pcz;
  logic signed [33:0] nfront, nback, cz34;
  logic drop;
  assign pcx    = word_t'(coef_i[SLOT_PCX]);
  assign pcy    = word_t'(coef_i[SLOT_PCY]);
  assign pcz    = word_t'(coef_i[SLOT_PCZ]);
  assign nfront = -34'(word_t'(coef_i[SLOT_FRONT]));
  assign nback  = -34'(word_t'(coef_i[SLOT_BACK]));
  assign cz34   = 34'(c_q[2]);
  assign drop   = dclip_i && ((cz34 > nfront) || (cz34 < nback));

  logic               v3_q;
  logic signed [63:0] p1x_q, p2x_q, p1y_q, p2y_q;
  logic signed [32:0] d_q, dx_q, dy_q;
  logic [7:0]         col3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1x_q  <= c_q[0] * pcz;
      p2x_q  <= pcx * c_q[2];
      p1y_q  <= c_q[1] * pcz;
      p2y_q  <= pcy * c_q[2];
      d_q    <= 33'(pcz) - 33'(c_q[2]);
      dx_q   <= 33'(c_q[0]) - 33'(pcx);
      dy_q   <= 33'(c_q[1]) - 33'(pcy);
      col3_q <= col2_q;
      col2_q <= col1_q;
      col1_q <= color_i;
    end
  end

  // Stage 4: magnitudes and signs
  logic signed [64:0] nx, ny;
  logic               dneg;
  assign nx   = 65'(p1x_q) - 65'(p2x_q);
  assign ny   = 65'(p1y_q) - 65'(p2y_q);
  assign dneg = d_q[32];

  logic  v4_q;
  side_t side_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magx_o       <= nx[64] ? 64'(-nx) : nx[63:0];
      magy_o       <= ny[64] ? 64'(-ny) : ny[63:0];
      ad_o         <= dneg ? 33'(-d_q) : d_q;
      side_q.color <= col3_q;
      side_q.dx    <= dx_q;
      side_q.dy    <= dy_q;
      side_q.negx  <= nx[64] ^ dneg;
      side_q.negy  <= ny[64] ^ dneg;
      side_q.dzero <= (d_q == 33'sd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q && !drop;
      v4_q <= v3_q;
    end
  end

  assign vld_o  = v4_q;
  assign side_o = side_q;
  assign busy_o = v1_q | v2_q | v3_q | v4_q;

endmodule

FILE: src/pptp_div.sv
// Pipelined restoring divider for both axes, one quotient bit per stage.
// Depends on pptp_pkg.
module pptp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [63:0]         magx_i,
  input  logic [63:0]         magy_i,
  input  logic [32:0]         ad_i,
  input  pptp_pkg::side_t     side_i,
  output logic                vld_o,
  output logic [pptp_pkg::QBITS-1:0] qx_o,
  output logic [pptp_pkg::QBITS-1:0] qy_o,
  output logic                ovfx_o,
  output logic                ovfy_o,
  output pptp_pkg::side_t     side_o,
  output logic                busy_o
);
  import pptp_pkg::*;

  localparam int HI = 64 - QBITS;  // bits above the quotient window

  logic              vld_q  [QBITS+1];
  logic [32:0]       rx_q   [QBITS+1];
  logic [32:0]       ry_q   [QBITS+1];
  logic [QBITS-1:0]  mx_q   [QBITS+1];
  logic [QBITS-1:0]  my_q   [QBITS+1];
  logic [QBITS-1:0]  qx_q   [QBITS+1];
  logic [QBITS-1:0]  qy_q   [QBITS+1];
  logic [32:0]       ad_q   [QBITS+1];
  logic              ovx_q  [QBITS+1];
  logic              ovy_q  [QBITS+1];
  side_t             side_q [QBITS+1];

  // Quotient of 2^41 or more shows up in the top bits alone
  logic ovx, ovy;
  assign ovx = {(33-HI)'(0), magx_i[63:QBITS]} >= ad_i;
  assign ovy = {(33-HI)'(0), magy_i[63:QBITS]} >= ad_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]   <= ovx ? '0 : {(33-HI)'(0), magx_i[63:QBITS]};
      ry_q[0]   <= ovy ? '0 : {(33-HI)'(0), magy_i[63:QBITS]};
      mx_q[0]   <= magx_i[QBITS-1:0];
      my_q[0]   <= magy_i[QBITS-1:0];
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      ad_q[0]   <= ad_i;
      ovx_q[0]  <= ovx;
      ovy_q[0]  <= ovy;
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en_i) vld_q[0] <= vld_i;
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_stage
    logic [33:0] sx, sy;
    assign sx = div_step(rx_q[k-1], mx_q[k-1][QBITS-1], ad_q[k-1]);
    assign sy = div_step(ry_q[k-1], my_q[k-1][QBITS-1], ad_q[k-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k]   <= sx[32:0];
        ry_q[k]   <= sy[32:0];
        qx_q[k]   <= {qx_q[k-1][QBITS-2:0], sx[33]};
        qy_q[k]   <= {qy_q[k-1][QBITS-2:0], sy[33]};
        mx_q[k]   <= {mx_q[k-1][QBITS-2:0], 1'b0};
        my_q[k]   <= {my_q[k-1][QBITS-2:0], 1'b0};
        ad_q[k]   <= ad_q[k-1];
        ovx_q[k]  <= ovx_q[k-1];
        ovy_q[k]  <= ovy_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else if (en_i) vld_q[k] <= vld_q[k-1];
    end
  end

  logic [QBITS:0] vld_vec;
  for (genvar k = 0; k <= QBITS; k++) begin : g_busy
    assign vld_vec[k] = vld_q[k];
  end

  assign vld_o  = vld_q[QBITS];
  assign qx_o   = qx_q[QBITS];
  assign qy_o   = qy_q[QBITS];
  assign ovfx_o = ovx_q[QBITS];
  assign ovfy_o = ovy_q[QBITS];
  assign side_o = side_q[QBITS];
  assign busy_o = |vld_vec;

endmodule

FILE: src/pptp_map.sv
// Projection select, window test, viewport map, rounding and index (five stages).
// Depends on pptp_pkg.
module pptp_map #(
  parameter int SCREEN_WIDTH  = pptp_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pptp_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [pptp_pkg::QBITS-1:0] qx_i,
  input  logic [pptp_pkg::QBITS-1:0] qy_i,
  input  logic                ovfx_i,
  input  logic                ovfy_i,
  input  pptp_pkg::side_t     side_i,
  input  logic                persp_i,
  input  pptp_pkg::coef_t     coef_i,
  output logic                vld_o,
  output logic [19:0]         index_o,
  output logic [7:0]          color_o,
  output logic                busy_o
);
  import pptp_pkg::*;

  localparam logic signed [63:0] NW = 64'(SCREEN_WIDTH);
  localparam logic signed [63:0] NH = 64'(SCREEN_HEIGHT);
  localparam logic signed [63:0] NPIX = 64'(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam logic [QBITS-1:0]   QSAT = QBITS'(1) << (QBITS-1);
  localparam logic signed [QBITS:0] PSAT = (QBITS+1)'(QSAT);

  function automatic logic signed [QBITS:0] axis_val(
      input logic persp, input logic dzero, input logic neg, input logic ovf,
      input logic [QBITS-1:0] q, input logic signed [32:0] diff);
    logic [QBITS-1:0] qs;
    qs = (ovf || (q > QSAT)) ? QSAT : q;
    if (!persp) return (QBITS+1)'(diff);
    if (dzero) begin
      if (diff > 33'sd0) return PSAT;
      if (diff < 33'sd0) return -PSAT;
      return '0;
    end
    return neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  endfunction

  // M1: projected coordinates
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [QBITS:0] x_q, y_q;
  logic [7:0] c1_q, c2_q, c3_q, c4_q, c5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= axis_val(persp_i, side_i.dzero, side_i.negx, ovfx_i, qx_i, side_i.dx);
      y_q  <= axis_val(persp_i, side_i.dzero, side_i.negy, ovfy_i, qy_i, side_i.dy);
      c1_q <= side_i.color;
    end
  end

  // M2: window test; offsets from the low bounds fit 32 bits when inside
  logic signed [QBITS+1:0] wxl, wxh, wyl, wyh, ex, ey;
  logic inwin;
  assign wxl   = (QBITS+2)'(word_t'(coef_i[SLOT_WXL]));
  assign wxh   = (QBITS+2)'(word_t'(coef_i[SLOT_WXH]));
  assign wyl   = (QBITS+2)'(word_t'(coef_i[SLOT_WYL]));
  assign wyh   = (QBITS+2)'(word_t'(coef_i[SLOT_WYH]));
  assign ex    = (QBITS+2)'(x_q) - wxl;
  assign ey    = (QBITS+2)'(y_q) - wyl;
  assign inwin = ((QBITS+2)'(x_q) >= wxl) && ((QBITS+2)'(x_q) <= wxh) &&
                 ((QBITS+2)'(y_q) >= wyl) && ((QBITS+2)'(y_q) <= wyh);

  logic [31:0] ux_q, uy_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= ex[31:0];
      uy_q <= ey[31:0];
      c2_q <= c1_q;
    end
  end

  // M3: scale
  logic signed [64:0] sx_q, sy_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= $signed({1'b0, ux_q}) * word_t'(coef_i[SLOT_WSX]);
      sy_q <= $signed({1'b0, uy_q}) * word_t'(coef_i[SLOT_WSY]);
      c3_q <= c2_q;
    end
  end

  // M4: offset, then scale to the screen size
  logic signed [49:0] ox, oy;
  assign ox = 50'(sx_q >>> 16) + 50'(word_t'(coef_i[SLOT_VXL]));
  assign oy = 50'(sy_q >>> 16) + 50'(word_t'(coef_i[SLOT_VYL]));

  logic signed [63:0] nx_q, ny_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q <= 64'(ox) * NW;
      ny_q <= 64'(oy) * NH;
      c4_q <= c3_q;
    end
  end

  // M5: round half up, mirror into the framebuffer index
  logic signed [63:0] xi, yi, pos;
  logic inrange;
  assign xi      = (nx_q + 64'sd32768) >>> 16;
  assign yi      = (ny_q + 64'sd32768) >>> 16;
  assign pos     = NW - xi + (NH - yi - 64'sd1) * NW;
  assign inrange = (pos > 64'sd0) && (pos < NPIX);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      index_o <= pos[19:0];
      c5_q    <= c4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q && inwin;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q && inrange;
    end
  end

  assign vld_o   = v5_q;
  assign color_o = c5_q;
  assign busy_o  = v1_q | v2_q | v3_q | v4_q;

endmodule

FILE: src/point_projection_to_pixel.sv
// Top level: coefficient store, config registers, stage chaining, stream ports.
// Depends on pptp_pkg, pptp_view, pptp_div, pptp_map and assert_macros.svh.
//
//  channel   | dir | payload
//  s_axis    | in  | tuser: kind; tdata: slot, coeff_value, px, py, pz, color_index
//  m_axis    | out | tdata: pixel_index, pixel_color
//  cfg       | in  | cfg_idx_i selects perspective_mode / depth_clip_enable
//
// One point enters per cycle while the output is not stalled; a result leaves after the
// 4 view stages, 42 divider stages (setup, then one quotient bit each) and 5 mapping stages.
// Reset clears the coefficient store, config bits and all valid bits at once.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// A coefficient load waits until no point is in flight, then is written into the store.
`include "assert_macros.svh"

module point_projection_to_pixel #(
  parameter int SCREEN_WIDTH  = pptp_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pptp_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // slot[4:0] coeff_value[36:5] px[68:37] py[100:69] pz[132:101] color_index[140:133]
  input  logic [143:0] s_axis_tdata_i,
  // kind[0]
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pixel_index[19:0] pixel_color[27:20]
  output logic [31:0]  m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [0:0]   cfg_data_i
);
  import pptp_pkg::*;

  logic en, s_acc, busy, is_point;
  logic view_busy, div_busy, map_busy;

  logic [4:0]  slot;
  word_t       coeff, px, py, pz;
  logic [7:0]  color;
  assign slot  = s_axis_tdata_i[4:0];
  assign coeff = word_t'(s_axis_tdata_i[36:5]);
  assign px    = word_t'(s_axis_tdata_i[68:37]);
  assign py    = word_t'(s_axis_tdata_i[100:69]);
  assign pz    = word_t'(s_axis_tdata_i[132:101]);
  assign color = s_axis_tdata_i[140:133];

  assign is_point        = (kind_e'(s_axis_tuser_i) == KIND_POINT);
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign busy            = view_busy | div_busy | map_busy;
  assign s_axis_tready_o = en && (is_point || !busy);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  coef_t coef_q;
  logic  persp_q, dclip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (s_acc && !is_point) begin
      coef_q[slot] <= coeff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persp_q <= 1'b0;
      dclip_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PERSP: persp_q <= cfg_data_i[0];
        REG_DCLIP: dclip_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic        v_vld;
  logic [63:0] v_magx, v_magy;
  logic [32:0] v_ad;
  side_t       v_side;

  pptp_view u_view (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (s_acc && is_point),
    .px_i    (px),
    .py_i    (py),
    .pz_i    (pz),
    .color_i (color),
    .dclip_i (dclip_q),
    .coef_i  (coef_q),
    .vld_o   (v_vld),
    .magx_o  (v_magx),
    .magy_o  (v_magy),
    .ad_o    (v_ad),
    .side_o  (v_side),
    .busy_o  (view_busy)
  );

  logic             d_vld, d_ovfx, d_ovfy;
  logic [QBITS-1:0] d_qx, d_qy;
  side_t            d_side;

  pptp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (v_vld),
    .magx_i  (v_magx),
    .magy_i  (v_magy),
    .ad_i    (v_ad),
    .side_i  (v_side),
    .vld_o   (d_vld),
    .qx_o    (d_qx),
    .qy_o    (d_qy),
    .ovfx_o  (d_ovfx),
    .ovfy_o  (d_ovfy),
    .side_o  (d_side),
    .busy_o  (div_busy)
  );

  logic [19:0] pix_index;
  logic [7:0]  pix_color;

  pptp_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (d_vld),
    .qx_i    (d_qx),
    .qy_i    (d_qy),
    .ovfx_i  (d_ovfx),
    .ovfy_i  (d_ovfy),
    .side_i  (d_side),
    .persp_i (persp_q),
    .coef_i  (coef_q),
    .vld_o   (m_axis_tvalid_o),
    .index_o (pix_index),
    .color_o (pix_color),
    .busy_o  (map_busy)
  );

  assign m_axis_tdata_o = {4'b0, pix_color, pix_index};

  `PPTP_ASSERT_IMPL(a_load_drained, s_acc && !is_point, !busy, "load taken with points in flight")
  `PPTP_ASSERT_IMPL(a_ready_advances, s_axis_tready_o, en, "ready while pipeline frozen")
  `PPTP_ASSERT_NEXT(a_stall_freezes, !en, $stable({view_busy, div_busy, map_busy}), "stall moved pipeline")

endmodule

FILE: tb/sv/tb_point_projection_to_pixel.sv
// Testbench for point_projection_to_pixel: drives coefficient loads and points,
// predicts each pixel word in SystemVerilog and checks the output stream.
// Depends on pptp_pkg and the RTL of point_projection_to_pixel.
module tb_point_projection_to_pixel;
  timeunit 1ns;
  timeprecision 1ps;
  import pptp_pkg::*;

  localparam int W = 1024;
  localparam int H = 768;
  localparam longint PSAT = 64'sd1 << 40;
  localparam int LATENCY = 60;
  localparam longint CYCLE_LIMIT = 900000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_idx_i = '0;
  logic [0:0]   cfg_data_i = '0;

  point_projection_to_pixel DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] coeffs [32];
  logic        persp_on, dclip_on;
  logic [27:0] pixel_words [$];
  int          errors = 0;
  longint      cycles = 0;
  int          hold_off = 0;
  int          sink_wait = 0;
  int          sink_draw;
  bit          sink_random = 1'b1;

  function automatic longint cw(int i);
    return longint'(signed'(coeffs[i]));
  endfunction

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cam_axis(longint x, longint y, longint z, int col);
    return sat_word(fl16(x * cw(col)) + fl16(y * cw(3 + col)) + fl16(z * cw(6 + col))
                    + cw(9 + col));
  endfunction

  function automatic longint persp_div(longint a, longint pa, longint cz, longint pcz);
    longint d, num, q;
    d = pcz - cz;
    if (d == 0) begin
      if (a - pa > 0) return PSAT;
      if (a - pa < 0) return -PSAT;
      return 0;
    end
    num = a * pcz - pa * cz;  // fits: each product at most 2^62 in magnitude
    q = num / d;              // truncates toward zero
    if (q > PSAT) q = PSAT;
    if (q < -PSAT) q = -PSAT;
    return q;
  endfunction

  function automatic longint pixel_coord(longint v, longint lo, longint sc, longint off,
                                         longint n);
    longint s;
    s = fl16((v - lo) * sc) + off;
    return fl16(s * n + 32768);
  endfunction

  function automatic void predict_pixel(logic [143:0] d, logic kind);
    longint x, y, z, cx, cy, cz, xi, yi, pos;
    if (kind == KIND_LOAD) begin
      coeffs[d[4:0]] = d[36:5];
      return;
    end
    x = longint'(signed'(d[68:37]));
    y = longint'(signed'(d[100:69]));
    z = longint'(signed'(d[132:101]));
    cx = cam_axis(x, y, z, 0);
    cy = cam_axis(x, y, z, 1);
    cz = cam_axis(x, y, z, 2);
    if (dclip_on && (cz > -cw(SLOT_FRONT) || cz < -cw(SLOT_BACK))) return;
    if (persp_on) begin
      x = persp_div(cx, cw(SLOT_PCX), cz, cw(SLOT_PCZ));
      y = persp_div(cy, cw(SLOT_PCY), cz, cw(SLOT_PCZ));
    end else begin
      x = cx - cw(SLOT_PCX);
      y = cy - cw(SLOT_PCY);
    end
    if (!(x >= cw(SLOT_WXL) && x <= cw(SLOT_WXH) && y >= cw(SLOT_WYL)
          && y <= cw(SLOT_WYH))) return;
    xi = pixel_coord(x, cw(SLOT_WXL), cw(SLOT_WSX), cw(SLOT_VXL), W);
    yi = pixel_coord(y, cw(SLOT_WYL), cw(SLOT_WSY), cw(SLOT_VYL), H);
    pos = W - xi + (H - yi - 1) * W;
    if (pos <= 0 || pos >= W * H) return;
    pixel_words.push_back({d[140:133], pos[19:0]});
  endfunction

  // valid stays high after a word is taken; the next call or drain() settles it
  task automatic send_word(logic kind, logic [4:0] slot, logic [31:0] cval,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [7:0] color, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= {3'b0, color, pz, py, px, cval, slot};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_pixel({3'b0, color, pz, py, px, cval, slot}, kind);
  endtask

  task automatic load_coeff(int slot, logic [31:0] v);
    send_word(KIND_LOAD, 5'(slot), v, $urandom, $urandom, $urandom, 8'($urandom));
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [7:0] color, bit gaps = 1'b1);
    send_word(KIND_POINT, 5'($urandom), $urandom, px, py, pz, color, gaps);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pixel_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_PERSP) persp_on = v; else dclip_on = v;
  endtask

  // identity-like scene: window [-4,4], scale maps 8 units onto the screen
  task automatic load_scene(bit random_touch);
    for (int i = 0; i < 12; i++)
      load_coeff(i, (i == 0 || i == 4 || i == 8) ? 32'h0001_0000 : 32'h0);
    load_coeff(SLOT_PCX, 0);
    load_coeff(SLOT_PCY, 0);
    load_coeff(SLOT_PCZ, 32'h000A_0000);
    load_coeff(SLOT_WXL, -32'sh0004_0000);
    load_coeff(SLOT_WXH, 32'h0004_0000);
    load_coeff(SLOT_WYL, -32'sh0004_0000);
    load_coeff(SLOT_WYH, 32'h0004_0000);
    load_coeff(SLOT_WSX, 32'h0000_2000);
    load_coeff(SLOT_WSY, 32'h0000_2000);
    load_coeff(SLOT_VXL, 0);
    load_coeff(SLOT_VYL, 0);
    load_coeff(SLOT_FRONT, 32'h0000_8000);
    load_coeff(SLOT_BACK, 32'h0008_0000);
    if (random_touch)
      for (int i = 0; i < 4; i++)
        load_coeff($urandom_range(0, 24), $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
  endtask

  function automatic logic [31:0] scene_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
    endcase
  endfunction

  task automatic test_reset_defaults();
    // all coefficients zero: every point lands on a zero window
    send_point(0, 0, 0, 8'h00);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 8'hff);
    load_coeff(25, 32'hffff_ffff);
    load_coeff(31, 32'h8000_0000);
  endtask

  task automatic test_directed();
    load_scene(1'b0);
    send_point(0, 0, 0, 8'h5a);
    send_point(32'h0004_0000, 32'h0004_0000, 0, 8'hff);
    send_point(-32'sh0004_0000, -32'sh0004_0000, 0, 8'h01);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 8'h80);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h7f);
    send_point(32'h0001_8000, -32'sh0002_0000, -32'sh0001_0000, 8'h33);
    write_reg(REG_PERSP, 1'b1);
    send_point(32'h0001_0000, 32'h0001_0000, -32'sh0002_0000, 8'h11);
    // cz equal to center z: zero divisor, signs +, -, 0
    send_point(32'h0001_0000, -32'sh0001_0000, 32'h000A_0000, 8'h22);
    send_point(0, 0, 32'h000A_0000, 8'h44);
    write_reg(REG_DCLIP, 1'b1);
    send_point(0, 0, -32'sh0001_0000, 8'h55);
    send_point(0, 0, 32'h0001_0000, 8'h66);
    send_point(0, 0, -32'sh0010_0000, 8'h77);
    // inverted window drops everything
    load_coeff(SLOT_WXL, 32'h0004_0000);
    load_coeff(SLOT_WXH, -32'sh0004_0000);
    send_point(0, 0, -32'sh0001_0000, 8'h88);
    write_reg(REG_PERSP, 1'b0);
    write_reg(REG_DCLIP, 1'b0);
  endtask

  task automatic test_random_phase(bit persp, bit dclip, int n);
    write_reg(REG_PERSP, persp);
    write_reg(REG_DCLIP, dclip);
    load_scene(1'b1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        load_coeff($urandom_range(0, 31), $urandom);
      else
        send_point(scene_coord(), scene_coord(),
                   dclip ? (-scene_coord()) : scene_coord(), 8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    // parallel, no depth clip: points at z = 0 must produce words
    write_reg(REG_PERSP, 1'b0);
    write_reg(REG_DCLIP, 1'b0);
    load_scene(1'b0);
    drain();
    hold_off = 200;
    for (int i = 0; i < 120; i++)
      send_point($urandom_range(0, 32'h0006_0000) - 32'h0003_0000,
                 $urandom_range(0, 32'h0006_0000) - 32'h0003_0000, 0, 8'(i), 1'b0);
    // pause until all results are back
    drain();
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: a drawn wait after every taken word, plus a counted hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready_i <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      sink_draw = sink_random ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 3) == 0) sink_draw = 0;
      m_axis_tready_i <= (sink_draw == 0);
      sink_wait <= (sink_draw == 0) ? 0 : sink_draw - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pixel_words.size() == 0) begin
        $display("%0t: unexpected pixel word %h", $time, m_axis_tdata_o[27:0]);
        errors++;
      end else begin
        logic [27:0] exp_w;
        exp_w = pixel_words.pop_front();
        if (m_axis_tdata_o[19:0] !== exp_w[19:0]) begin
          $display("%0t: pixel_index expected %0d actual %0d", $time, exp_w[19:0],
                   m_axis_tdata_o[19:0]);
          errors++;
        end
        if (m_axis_tdata_o[27:20] !== exp_w[27:20]) begin
          $display("%0t: pixel_color expected %0d actual %0d", $time, exp_w[27:20],
                   m_axis_tdata_o[27:20]);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) coeffs[i] = '0;
    persp_on = 1'b0;
    dclip_on = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_phase(1'b0, 1'b0, 300);
    test_random_phase(1'b1, 1'b0, 300);
    test_random_phase(1'b1, 1'b1, 200);
    sink_random = 1'b0;
    test_random_phase(1'b0, 1'b1, 150);
    sink_random = 1'b1;
    test_backpressure();
    drain();
    if (errors == 0 && pixel_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+src
src/pptp_pkg.sv
src/pptp_view.sv
src/pptp_div.sv
src/pptp_map.sv
src/point_projection_to_pixel.sv
tb/sv/tb_point_projection_to_pixel.sv
